/* rtl/core/ddmw_pkg.sv */
// Shared types and constants for the differential drive mixer with watchdog.
// No dependencies; the mixer module refers to this package.
package ddmw_pkg;

  // Input item codes
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_HALF_BASE = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  // Register reset values
  localparam logic [9:0]  HALF_BASE_RST = 10'd75;
  localparam logic [15:0] GAIN_RST      = 16'd30385;
  localparam logic [15:0] TIMEOUT_RST   = 16'd500;

  // Speed in um/s fits 27 bits signed; magnitudes 27 bits unsigned
  localparam int SPEED_W = 27;
  localparam int QUOT_W  = 18;

  // Divide by 1000: q0 = (x * floor(2^27 / 1000)) >> 27, then one correction
  localparam int                 RECIP_SHIFT = 27;
  localparam logic [QUOT_W-1:0]  RECIP_MULT  = 18'd134217;
  localparam logic signed [18:0] MILLI       = 19'sd1000;

  localparam logic [15:0] TICK_SAT = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TURN,
    ST_VEL,
    ST_SUM,
    ST_GAIN,
    ST_RECIP,
    ST_FIX,
    ST_CORR,
    ST_OUT
  } state_t;

endpackage

/* rtl/core/ddmw_if.sv */
// Valid/ready channel interfaces for the drive mixer: command in, duties out.
// Independent of the package.
interface ddmw_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] linear_velocity;
  logic signed [15:0] angular_velocity;

  modport source (output valid, opcode, linear_velocity, angular_velocity, input ready);
  modport sink   (input valid, opcode, linear_velocity, angular_velocity, output ready);
endinterface

interface ddmw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_forward;
  logic [7:0] left_reverse;
  logic [7:0] right_forward;
  logic [7:0] right_reverse;
  logic [7:0] indicator_level;
  logic       halted;

  modport source (output valid, left_forward, left_reverse, right_forward, right_reverse,
                  indicator_level, halted, input ready);
  modport sink   (input valid, left_forward, left_reverse, right_forward, right_reverse,
                  indicator_level, halted, output ready);
endinterface

/* rtl/core/diff_drive_mixer_watchdog.sv */
// Differential drive mixer with command watchdog; uses ddmw_pkg and ddmw_if.
// A new command or tick is accepted only in the idle state, once the previous result has
//   been loaded; the single shared multiplier, stepped through three multiplies per wheel
//   plus two setup multiplies, sets the pace of a command. The result register frees the
//   output side early.
// Reset (rst, synchronous): registers to defaults, duties zero, halted set.
module diff_drive_mixer_watchdog #(
  parameter int DUTY_MAX = 255
) (
  input  logic              clk,
  input  logic              rst,
  ddmw_in_if.sink           cmd,
  ddmw_out_if.source        rsp,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int DUTY_W = $clog2(DUTY_MAX + 1);
  localparam int SW     = ddmw_pkg::SPEED_W;
  localparam int QW     = ddmw_pkg::QUOT_W;

  // Configuration registers
  logic [9:0]  half_base;
  logic [15:0] gain;
  logic [15:0] timeout;

  // Architectural state
  logic [15:0]       elapsed;
  logic [15:0]       elapsed_next;
  logic              halted;
  logic [DUTY_W-1:0] lf_duty, lr_duty, rf_duty, rr_duty, led_duty;

  // Sequencer and working registers
  ddmw_pkg::state_t  state, state_next;
  logic              side;          // 0 left wheel, 1 right wheel
  logic signed [15:0] v_hold, w_hold;
  logic signed [SW-1:0] turn, vk;
  logic              neg;
  logic [SW-1:0]     mag;
  logic [SW-1:0]     xq;            // scaled speed awaiting divide by 1000
  logic [QW-1:0]     q0;
  logic [DUTY_W-1:0] left_mag;

  // Shared multiplier
  logic signed [27:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [46:0] prod;

  // Per-step combinational values
  logic signed [SW-1:0] sum_src, speed;
  logic [27:0]       rem;
  logic [QW-1:0]     q_fix;
  logic [DUTY_W-1:0] q_sat;
  logic              accept, rsp_load;

  assign cmd.ready = (state == ddmw_pkg::ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign rsp_load  = (state == ddmw_pkg::ST_OUT) && (!rsp.valid || rsp.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddmw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ddmw_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (cmd.opcode == ddmw_pkg::OP_TICK) ? ddmw_pkg::ST_OUT
                                                        : ddmw_pkg::ST_TURN;
        end
      end
      ddmw_pkg::ST_TURN:  state_next = ddmw_pkg::ST_VEL;
      ddmw_pkg::ST_VEL:   state_next = ddmw_pkg::ST_SUM;
      ddmw_pkg::ST_SUM:   state_next = ddmw_pkg::ST_GAIN;
      ddmw_pkg::ST_GAIN:  state_next = ddmw_pkg::ST_RECIP;
      ddmw_pkg::ST_RECIP: state_next = ddmw_pkg::ST_FIX;
      ddmw_pkg::ST_FIX:   state_next = ddmw_pkg::ST_CORR;
      ddmw_pkg::ST_CORR:  state_next = side ? ddmw_pkg::ST_OUT : ddmw_pkg::ST_SUM;
      ddmw_pkg::ST_OUT: begin
        if (rsp_load) begin
          state_next = ddmw_pkg::ST_IDLE;
        end
      end
      default:            state_next = ddmw_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operand select: one product per multiply step, registered into prod
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ddmw_pkg::ST_TURN: begin
        mul_a = 28'(w_hold);
        mul_b = {9'b0, half_base};
      end
      ddmw_pkg::ST_VEL: begin
        mul_a = 28'(v_hold);
        mul_b = ddmw_pkg::MILLI;
      end
      ddmw_pkg::ST_GAIN: begin
        mul_a = {1'b0, mag};
        mul_b = {3'b0, gain};
      end
      ddmw_pkg::ST_RECIP: begin
        mul_a = {1'b0, prod[SW+15:16]};           // speed * gain / 2^16
        mul_b = {1'b0, ddmw_pkg::RECIP_MULT};
      end
      ddmw_pkg::ST_FIX: begin
        mul_a = {10'b0, prod[ddmw_pkg::RECIP_SHIFT+QW-1:ddmw_pkg::RECIP_SHIFT]};
        mul_b = ddmw_pkg::MILLI;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Wheel speed: 1000*v minus turn on the left, plus turn on the right
  assign sum_src = side ? vk : prod[SW-1:0];
  assign speed   = side ? (sum_src + turn) : (sum_src - turn);

  // Quotient correction: q0 is exact or one short
  assign rem   = {1'b0, xq} - prod[27:0];
  assign q_fix = (rem >= 28'd1000) ? (q0 + QW'(1)) : q0;
  assign q_sat = (q_fix > QW'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : DUTY_W'(q_fix);

  assign elapsed_next = (elapsed != ddmw_pkg::TICK_SAT) ? (elapsed + 16'd1) : elapsed;

  // Configuration writes, to be made only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      half_base <= ddmw_pkg::HALF_BASE_RST;
      gain      <= ddmw_pkg::GAIN_RST;
      timeout   <= ddmw_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ddmw_pkg::REG_HALF_BASE: half_base <= cfg_data[9:0];
        ddmw_pkg::REG_GAIN:      gain      <= cfg_data;
        ddmw_pkg::REG_TIMEOUT:   timeout   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Watchdog and duty state
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed  <= '0;
      halted   <= 1'b1;
      lf_duty  <= '0;
      lr_duty  <= '0;
      rf_duty  <= '0;
      rr_duty  <= '0;
      led_duty <= '0;
    end else begin
      if (accept) begin
        if (cmd.opcode == ddmw_pkg::OP_COMMAND) begin
          elapsed <= '0;
          halted  <= 1'b0;
        end else begin
          elapsed <= elapsed_next;
          // timeout: stop everything once
          if (!halted && (elapsed_next > timeout)) begin
            halted   <= 1'b1;
            lf_duty  <= '0;
            lr_duty  <= '0;
            rf_duty  <= '0;
            rr_duty  <= '0;
            led_duty <= '0;
          end
        end
      end
      if (state == ddmw_pkg::ST_CORR) begin
        if (!side) begin
          lf_duty <= neg ? '0 : q_sat;
          lr_duty <= neg ? q_sat : '0;
        end else begin
          rf_duty  <= neg ? '0 : q_sat;
          rr_duty  <= neg ? q_sat : '0;
          led_duty <= (left_mag > q_sat) ? left_mag : q_sat;
        end
      end
    end
  end

  // Side selector
  always_ff @(posedge clk) begin
    if (rst) begin
      side <= 1'b0;
    end else if (state == ddmw_pkg::ST_TURN) begin
      side <= 1'b0;
    end else if (state == ddmw_pkg::ST_CORR) begin
      side <= 1'b1;
    end
  end

  // Datapath working registers (no reset needed)
  always_ff @(posedge clk) begin
    if (accept) begin
      v_hold <= cmd.linear_velocity;
      w_hold <= cmd.angular_velocity;
    end
    case (state)
      ddmw_pkg::ST_TURN: prod <= mul_a * mul_b;
      ddmw_pkg::ST_VEL: begin
        turn <= prod[SW-1:0];
        prod <= mul_a * mul_b;
      end
      ddmw_pkg::ST_SUM: begin
        if (!side) begin
          vk <= prod[SW-1:0];
        end
        neg <= speed[SW-1];
        mag <= speed[SW-1] ? SW'(-speed) : SW'(speed);
      end
      ddmw_pkg::ST_GAIN: prod <= mul_a * mul_b;
      ddmw_pkg::ST_RECIP: begin
        xq   <= prod[SW+15:16];
        prod <= mul_a * mul_b;
      end
      ddmw_pkg::ST_FIX: begin
        q0   <= prod[ddmw_pkg::RECIP_SHIFT+QW-1:ddmw_pkg::RECIP_SHIFT];
        prod <= mul_a * mul_b;
      end
      ddmw_pkg::ST_CORR: begin
        if (!side) begin
          left_mag <= q_sat;
        end
      end
      default: ;
    endcase
  end

  // Result register: holds a transfer until taken, low 8 bits of each duty
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.left_forward    <= 8'(lf_duty);
      rsp.left_reverse    <= 8'(lr_duty);
      rsp.right_forward   <= 8'(rf_duty);
      rsp.right_reverse   <= 8'(rr_duty);
      rsp.indicator_level <= 8'(led_duty);
      rsp.halted          <= halted;
    end
  end

endmodule

/* rtl/core/ddmw_checker.sv */
// Port-level checks for the drive mixer, bound onto the top level.
// Depends on diff_drive_mixer_watchdog and its channel interfaces.
module ddmw_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] lf,
  input logic [7:0] lr,
  input logic [7:0] rf,
  input logic [7:0] rr,
  input logic [7:0] led,
  input logic       halted
);

  // A halted drive shows no duty anywhere
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && halted |-> (lf == 8'd0) && (lr == 8'd0) && (rf == 8'd0) &&
                            (rr == 8'd0) && (led == 8'd0))
    else $error("halted result carries nonzero duty");

  // Forward and reverse of one wheel are never both driven
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !((lf != 8'd0) && (lr != 8'd0)) && !((rf != 8'd0) && (rr != 8'd0)))
    else $error("both directions driven on one wheel");

  // Indicator follows one of the wheel magnitudes
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (led == (lf | lr)) || (led == (rf | rr)))
    else $error("indicator does not match a wheel duty");

  // Block is busy right after taking an item
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("ready right after a transfer");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({lf, lr, rf, rr, led, halted}))
    else $error("stalled result changed");

endmodule

bind diff_drive_mixer_watchdog ddmw_port_checks u_ddmw_port_checks (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .lf        (rsp.left_forward),
  .lr        (rsp.left_reverse),
  .rf        (rsp.right_forward),
  .rr        (rsp.right_reverse),
  .led       (rsp.indicator_level),
  .halted    (rsp.halted)
);
